@@ hdl/bptm_pkg.sv @@
// Package for the battery pack table monitor: item kinds, slot record type,
// register indexes and fault masks. No dependencies.
package bptm_pkg;

    localparam int ID_W = 29;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_FLAGS   = 2'd1,
        KIND_REFRESH = 2'd2,
        KIND_POWER   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_ID_MASK   = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_IDLE      = 2'd2,
        REG_DISCHARGE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [7:0]      charge;
        logic            running;
        logic [1:0]      mode;
        logic [15:0]     faults;
        logic [31:0]     stamp;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_WRITE,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [11:0] OVERHEAT_MASK = 12'h078;
    localparam logic [11:0] WARNING_MASK  = 12'hF87;

endpackage

@@ hdl/bptm_slot_ram.sv @@
// Slot memory of the battery pack monitor: one write port, one registered
// read port. Uses bptm_pkg for the slot record.
module bptm_slot_ram #(
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  bptm_pkg::slot_t    wdata,
    input  logic [AW-1:0]      raddr,
    output bptm_pkg::slot_t    rdata
);
    import bptm_pkg::*;

    slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/bptm_divider.sv @@
// Restoring divider for the charge average: one quotient bit per cycle.
// Uses nothing outside this file.
module bptm_divider #(
    parameter int NW = 12,
    parameter int DW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quot_reg, quot_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] div_reg, div_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DW-1:0], quot_reg[NW-1]};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next  = trial - {1'b0, div_reg};
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

@@ hdl/battery_pack_table_monitor.sv @@
// Top level of the battery pack table monitor: sequencer, slot scan and
// merged status. Depends on bptm_pkg, bptm_slot_ram and bptm_divider.
//
// One item at a time. Each accepted item scans every slot out of the slot
// memory (one read per cycle, read data registered), then writes back at
// most one slot per cycle. A refresh then runs the average divider on the
// charge sum (8+clog2(PACKS+1) bits); a refresh with no running pack skips
// the divider. The result sits in an output register; the next item is
// taken once it has been transferred. Claimed bits and written bits of the
// slots are flip-flops cleared at reset; a slot that was never written reads
// as its reset contents.
module battery_pack_table_monitor #(
    parameter int PACKS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [28:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [28:0] frame_id,
    input  logic [15:0] word2,
    input  logic [15:0] word3,
    input  logic [31:0] now_ms,
    input  logic        power_on,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  soc_average,
    output logic [11:0] event_bits,
    output logic        overheat,
    output logic        warning,
    output logic        system_started,
    output logic        send_command,
    output logic [2:0]  command_byte
);
    import bptm_pkg::*;

    localparam int AW = (PACKS > 1) ? $clog2(PACKS) : 1;
    localparam int CW = $clog2(PACKS + 1);
    localparam int SW = 8 + CW;
    localparam logic [1:0] IDLE_CODE_RESET = 2'd0;

    // Configuration.
    logic [28:0] id_mask_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  idle_reg, dis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_mask_reg <= 29'h1FFFFFFF;
            timeout_reg <= 16'd500;
            idle_reg    <= IDLE_CODE_RESET;
            dis_reg     <= 2'd1;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ID_MASK:   id_mask_reg <= cfg_data;
                REG_TIMEOUT:   timeout_reg <= cfg_data[15:0];
                REG_IDLE:      idle_reg    <= cfg_data[1:0];
                REG_DISCHARGE: dis_reg     <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    // Item latch.
    kind_t       kind_reg;
    logic [28:0] key_reg;
    logic [15:0] w2_reg, w3_reg;
    logic [31:0] now_reg;
    logic        on_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg;
    logic [PACKS-1:0] valid_reg;
    logic [PACKS-1:0] init_reg;
    logic [PACKS-1:0] mvalid_raw;

    // Scan accumulators.
    logic          match_found_reg, free_found_reg;
    logic [AW-1:0] match_idx_reg, free_idx_reg;
    logic          all_run_reg, all_stop_reg, all_dis_reg, all_idle_reg;
    logic [15:0]   flags_reg;
    logic [SW-1:0] sum_reg;
    logic [CW-1:0] cnt_reg;
    logic [PACKS-1:0] stale_reg;
    logic          pw_all_run, pw_all_stop, pw_all_dis, pw_all_idle;
    logic          cur_stale;
    logic          div_start_done_reg;

    // Record of the slot that a status or flags frame lands in, captured
    // while the scan passes over it.
    slot_t tgt_rec_reg;

    // Merged status and output registers.
    logic [7:0]  soc_reg;
    logic [11:0] ev_reg;
    logic        oh_reg, warn_reg, started_reg;
    logic        send_reg;
    logic [2:0]  cmd_reg;
    logic        out_valid_reg;

    // Memory.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    slot_t         ram_wdata, ram_rdata, cur;
    logic [AW-1:0] rd_idx_reg;

    bptm_slot_ram #(.DEPTH(PACKS), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic          div_start, div_busy;
    logic [SW-1:0] div_q;

    bptm_divider #(.NW(SW), .DW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign mvalid_raw = valid_reg;

    // A slot that was never written reads as its reset contents.
    always_comb
    begin
        cur = ram_rdata;
        if (!init_reg[rd_idx_reg])
        begin
            cur.id      = '0;
            cur.charge  = '0;
            cur.running = 1'b0;
            cur.mode    = IDLE_CODE_RESET;
            cur.faults  = '0;
            cur.stamp   = '0;
        end
    end

    logic          accept;
    logic          last_idx;
    logic [AW-1:0] tgt_idx;
    logic [31:0]   age;
    logic          scan_done;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign age       = now_reg - cur.stamp;
    // The read data is registered and trails the read address, so the last slot
    // is on cur once the address counter has reached PACKS.
    assign last_idx  = (idx_reg == CW'(PACKS));
    assign scan_done = (idx_reg == CW'(PACKS));

    always_comb
    begin
        priority if (match_found_reg)
            tgt_idx = match_idx_reg;
        else if (free_found_reg)
            tgt_idx = free_idx_reg;
        else
            tgt_idx = '0;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_SCAN_RD;
            ST_SCAN_RD: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (last_idx)
                begin
                    priority if (kind_reg == KIND_REFRESH)
                        state_next = ST_WRITE;
                    else if (kind_reg == KIND_POWER)
                        state_next = ST_OUT;
                    else
                        state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (kind_reg != KIND_REFRESH)
                    state_next = ST_OUT;
                else if (scan_done)
                    state_next = ST_DIV;
            end
            ST_DIV:     if (!div_start && !div_busy) state_next = ST_OUT;
            ST_OUT:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        ram_raddr = idx_reg[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = tgt_idx;
        ram_wdata = tgt_rec_reg;
        if (state_reg == ST_WRITE)
        begin
            unique case (kind_reg)
                KIND_STATUS:
                begin
                    ram_we = 1'b1;
                    ram_wdata.charge  = w2_reg[7:0];
                    ram_wdata.id      = key_reg;
                    ram_wdata.running = 1'b1;
                    ram_wdata.stamp   = now_reg;
                end
                KIND_FLAGS:
                begin
                    ram_we = 1'b1;
                    ram_wdata.faults = w3_reg;
                    ram_wdata.mode   = {w3_reg[12], w3_reg[13]};
                end
                KIND_REFRESH:
                begin
                    // A stale slot is cleared to zero with its mode set to the idle code.
                    if (!scan_done && stale_reg[idx_reg[AW-1:0]])
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = idx_reg[AW-1:0];
                        ram_wdata      = '0;
                        ram_wdata.mode = idle_reg;
                    end
                end
                default: ;
            endcase
        end
        div_start = (state_reg == ST_DIV) && (cnt_reg != '0) && !div_start_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            valid_reg          <= '0;
            init_reg           <= '0;
            out_valid_reg      <= 1'b0;
            soc_reg            <= '0;
            ev_reg             <= '0;
            oh_reg             <= 1'b0;
            warn_reg           <= 1'b0;
            started_reg        <= 1'b0;
            idx_reg            <= '0;
            div_start_done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
                init_reg[ram_waddr] <= 1'b1;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    div_start_done_reg <= 1'b0;
                end
                ST_SCAN_RD: idx_reg <= idx_reg + 1'b1;
                ST_SCAN:
                begin
                    if (!last_idx)
                        idx_reg <= idx_reg + 1'b1;
                    else
                        idx_reg <= '0;
                    if (last_idx && kind_reg == KIND_POWER)
                    begin
                        if (on_reg)
                        begin
                            if (!pw_all_run && !pw_all_dis) ;
                            else started_reg <= 1'b1;
                        end
                        else if (pw_all_stop && pw_all_idle)
                        begin
                            started_reg <= 1'b0;
                            soc_reg     <= '0;
                            oh_reg      <= 1'b0;
                            warn_reg    <= 1'b1;
                        end
                    end
                end
                ST_WRITE:
                begin
                    if (kind_reg == KIND_STATUS)
                        valid_reg[tgt_idx] <= 1'b1;
                    if (kind_reg == KIND_REFRESH && !scan_done)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (stale_reg[idx_reg[AW-1:0]])
                            valid_reg[idx_reg[AW-1:0]] <= 1'b0;
                    end
                    if (kind_reg == KIND_REFRESH && scan_done)
                    begin
                        ev_reg   <= flags_reg[11:0];
                        oh_reg   <= (flags_reg[11:0] & OVERHEAT_MASK) != '0;
                        warn_reg <= (flags_reg[11:0] & WARNING_MASK) != '0;
                    end
                end
                ST_DIV:
                begin
                    if (div_start)
                        div_start_done_reg <= 1'b1;
                    if (state_next == ST_OUT)
                        soc_reg <= (cnt_reg == '0) ? 8'd0 : div_q[7:0];
                end
                ST_OUT:  out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Power decision flags including the slot read in the final scan cycle.
    assign pw_all_run  = all_run_reg && cur.running;
    assign pw_all_stop = all_stop_reg && !cur.running;
    assign pw_all_dis  = all_dis_reg && (cur.mode == dis_reg);
    assign pw_all_idle = all_idle_reg && (cur.mode == idle_reg);

    // Refresh: a stale slot is cleared; the merge uses post-clear contents.
    assign cur_stale = age > {16'd0, timeout_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_t'(kind);
            key_reg  <= frame_id & id_mask_reg;
            w2_reg   <= word2;
            w3_reg   <= word3;
            now_reg  <= now_ms;
            on_reg   <= power_on;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            match_idx_reg   <= '0;
            free_idx_reg    <= '0;
            all_run_reg     <= 1'b1;
            all_stop_reg    <= 1'b1;
            all_dis_reg     <= 1'b1;
            all_idle_reg    <= 1'b1;
            flags_reg       <= '0;
            sum_reg         <= '0;
            cnt_reg         <= '0;
            stale_reg       <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (mvalid_raw[rd_idx_reg] && cur.id == key_reg && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= rd_idx_reg;
            end
            if (!mvalid_raw[rd_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
            all_run_reg  <= pw_all_run;
            all_stop_reg <= pw_all_stop;
            all_dis_reg  <= pw_all_dis;
            all_idle_reg <= pw_all_idle;
            if (cur_stale)
            begin
                stale_reg[rd_idx_reg] <= 1'b1;
            end
            else
            begin
                flags_reg <= flags_reg | cur.faults;
                if (cur.running)
                begin
                    sum_reg <= sum_reg + SW'(cur.charge);
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            // Slot 0 is the fallback target; a later first match or an
            // earlier-unseen free slot takes over in the same order as tgt_idx.
            if (rd_idx_reg == '0)
                tgt_rec_reg <= cur;
            else if (!match_found_reg && mvalid_raw[rd_idx_reg] && cur.id == key_reg)
                tgt_rec_reg <= cur;
            else if (!match_found_reg && !free_found_reg && !mvalid_raw[rd_idx_reg])
                tgt_rec_reg <= cur;
        end
        rd_idx_reg <= ram_raddr;
        if (state_reg == ST_SCAN && last_idx)
        begin
            if (kind_reg == KIND_POWER)
            begin
                send_reg <= 1'b0;
                cmd_reg  <= '0;
                if (on_reg)
                begin
                    if (!pw_all_run && !pw_all_dis)
                    begin
                        send_reg <= 1'b1;
                        cmd_reg  <= {dis_reg, 1'b1};
                    end
                end
                else if (!pw_all_stop || !pw_all_idle)
                begin
                    send_reg <= 1'b1;
                    cmd_reg  <= {idle_reg, 1'b0};
                end
            end
            else
            begin
                send_reg <= 1'b0;
                cmd_reg  <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign soc_average    = soc_reg;
    assign event_bits     = ev_reg;
    assign overheat       = oh_reg;
    assign warning        = warn_reg;
    assign system_started = started_reg;
    assign send_command   = send_reg;
    assign command_byte   = cmd_reg;

endmodule

@@ hdl/bptm_checker.sv @@
// Port-level checker for the battery pack table monitor, bound to the top
// level. Uses only the top-level ports.
module bptm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        send_command,
    input logic [2:0]  command_byte,
    input logic [11:0] event_bits,
    input logic        overheat
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command_byte))
        else $error("result dropped while stalled");

    a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_command |-> command_byte == 3'd0)
        else $error("command byte without send");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    a_status_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(send_command) && $stable(event_bits)
                                   && $stable(overheat))
        else $error("status changed while stalled");

    a_overheat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overheat |-> (event_bits & 12'h078) != 12'd0)
        else $error("overheat without temperature fault");
endmodule

bind battery_pack_table_monitor bptm_checker u_bptm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .send_command (send_command),
    .command_byte (command_byte),
    .event_bits   (event_bits),
    .overheat     (overheat)
);

@@ verif/tb_battery_pack_table_monitor.sv @@
// Self-checking testbench for battery_pack_table_monitor: a directed table, then
// random phases under changing register settings, checked by a predictor or typed-in values.
// Depends on bptm_pkg and the RTL of the block.
module tb_battery_pack_table_monitor;
    import bptm_pkg::*;

    typedef struct packed {
        logic [7:0]  soc;
        logic [11:0] events;
        logic        hot;
        logic        warn;
        logic        started;
        logic        send;
        logic [2:0]  cmd;
    } pack_status_t;

    typedef struct {
        kind_t        k;
        logic [28:0]  id;
        logic [15:0]  w2;
        logic [15:0]  w3;
        logic [31:0]  now;
        logic         on;
        bit           typed;
        pack_status_t want;
    } stim_row_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [28:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    kind_t       kind = KIND_STATUS;
    logic [28:0] frame_id = '0;
    logic [15:0] word2 = '0;
    logic [15:0] word3 = '0;
    logic [31:0] now_ms = '0;
    logic        power_on = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [7:0]  soc_average;
    logic [11:0] event_bits;
    logic        overheat;
    logic        warning;
    logic        system_started;
    logic        send_command;
    logic [2:0]  command_byte;

    battery_pack_table_monitor #(.PACKS(2)) i_dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Predictor copy of the registers, the pack table and the merged status.
    logic [28:0] mask_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  idle_reg;
    logic [1:0]  discharge_reg;
    logic        tbl_valid [2];
    logic [28:0] tbl_id [2];
    logic [7:0]  tbl_charge [2];
    logic        tbl_running [2];
    logic [1:0]  tbl_mode [2];
    logic [15:0] tbl_faults [2];
    logic [31:0] tbl_stamp [2];
    pack_status_t merged;

    pack_status_t pending_status [$];
    int           mismatches = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;

    function automatic void clear_pack(int i);
        tbl_valid[i] = 0;
        tbl_id[i] = '0;
        tbl_charge[i] = '0;
        tbl_running[i] = 0;
        tbl_mode[i] = idle_reg;
        tbl_faults[i] = '0;
        tbl_stamp[i] = '0;
    endfunction

    function automatic int pick_pack(logic [28:0] key);
        for (int i = 0; i < 2; i++)
            if (tbl_valid[i] && tbl_id[i] == key)
                return i;
        for (int i = 0; i < 2; i++)
            if (!tbl_valid[i])
                return i;
        return 0;
    endfunction

    function automatic pack_status_t predict_status(stim_row_t r);
        logic [28:0]  key;
        int           i;
        int           sum;
        int           cnt;
        logic [15:0]  flags;
        bit           all_on;
        bit           all_off;
        bit           all_dis;
        bit           all_idle;
        pack_status_t res;
        key = r.id & mask_reg;
        merged.send = 0;
        merged.cmd = '0;
        case (r.k)
            KIND_STATUS:
            begin
                i = pick_pack(key);
                tbl_charge[i] = r.w2[7:0];
                tbl_id[i] = key;
                tbl_valid[i] = 1;
                tbl_running[i] = 1;
                tbl_stamp[i] = r.now;
            end
            KIND_FLAGS:
            begin
                i = pick_pack(key);
                tbl_faults[i] = r.w3;
                tbl_mode[i] = {r.w3[12], r.w3[13]};
            end
            KIND_REFRESH:
            begin
                flags = '0;
                sum = 0;
                cnt = 0;
                for (int j = 0; j < 2; j++)
                    if (32'(r.now - tbl_stamp[j]) > {16'd0, timeout_reg})
                        clear_pack(j);
                for (int j = 0; j < 2; j++)
                begin
                    flags |= tbl_faults[j];
                    if (tbl_running[j])
                    begin
                        sum += tbl_charge[j];
                        cnt++;
                    end
                end
                merged.events = flags[11:0];
                merged.hot = |(flags[11:0] & OVERHEAT_MASK);
                merged.warn = |(flags[11:0] & WARNING_MASK);
                merged.soc = cnt ? 8'(sum / cnt) : 8'd0;
            end
            default:
            begin
                all_on = 1;
                all_off = 1;
                all_dis = 1;
                all_idle = 1;
                for (int j = 0; j < 2; j++)
                begin
                    all_on &= tbl_running[j];
                    all_off &= !tbl_running[j];
                    all_dis &= (tbl_mode[j] == discharge_reg);
                    all_idle &= (tbl_mode[j] == idle_reg);
                end
                if (r.on)
                begin
                    if (!all_on && !all_dis)
                    begin
                        merged.send = 1;
                        merged.cmd = {discharge_reg, 1'b1};
                    end
                    else
                        merged.started = 1;
                end
                else if (!all_off || !all_idle)
                begin
                    merged.send = 1;
                    merged.cmd = {idle_reg, 1'b0};
                end
                else
                begin
                    merged.started = 0;
                    merged.soc = '0;
                    merged.hot = 0;
                    merged.warn = 1;
                end
            end
        endcase
        res = merged;
        return res;
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [28:0] value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            REG_ID_MASK:   mask_reg = value;
            REG_TIMEOUT:   timeout_reg = value[15:0];
            REG_IDLE:      idle_reg = value[1:0];
            default:       discharge_reg = value[1:0];
        endcase
    endtask

    // Drives one item and holds it until the transfer; the expectation is
    // queued at the accepting edge.
    task automatic send_item(stim_row_t r);
        pack_status_t p;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        kind <= r.k;
        frame_id <= r.id;
        word2 <= r.w2;
        word3 <= r.w3;
        now_ms <= r.now;
        power_on <= r.on;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        p = predict_status(r);
        pending_status.push_back(r.typed ? r.want : p);
    endtask

    always @(posedge clk)
    begin
        pack_status_t got;
        pack_status_t exp;
        if (out_valid && !out_stall)
        begin
            got = '{soc_average, event_bits, overheat, warning, system_started,
                    send_command, command_byte};
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", got);
            end
            else
            begin
                exp = pending_status.pop_front();
                if (got.soc !== exp.soc || got.events !== exp.events
                    || got.hot !== exp.hot || got.warn !== exp.warn
                    || got.started !== exp.started || got.send !== exp.send
                    || got.cmd !== exp.cmd)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status mismatch: expected %p, got %p", exp, got);
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic stim_row_t mk(kind_t k, logic [28:0] id, logic [15:0] w2,
                                     logic [15:0] w3, logic [31:0] now, logic on);
        stim_row_t r;
        r.k = k;
        r.id = id;
        r.w2 = w2;
        r.w3 = w3;
        r.now = now;
        r.on = on;
        r.typed = 0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(stim_row_t r, pack_status_t want);
        r.typed = 1;
        r.want = want;
        return r;
    endfunction

    task automatic drain;
        int guard;
        guard = 0;
        while (pending_status.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        in_valid <= 0;
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        stim_row_t    dir_table [$];
        stim_row_t    r;
        logic [28:0]  id_pool [4];
        logic [31:0]  clock_ms;
        int           sel;

        mask_reg = 29'h1FFF_FFFF;
        timeout_reg = 16'd500;
        idle_reg = 2'd0;
        discharge_reg = 2'd1;
        for (int i = 0; i < 2; i++)
            clear_pack(i);
        merged = '0;

        // Directed table; the expected status is typed in where it is obvious.
        dir_table.push_back(typed_row(mk(KIND_POWER, '0, '0, '0, '0, 0),
                                      '{8'd0, 12'd0, 0, 1, 0, 0, 3'd0}));
        dir_table.push_back(typed_row(mk(KIND_POWER, '0, '0, '0, '0, 1),
                                      '{8'd0, 12'd0, 0, 1, 0, 1, 3'd3}));
        dir_table.push_back(mk(KIND_STATUS, 29'h1FFF_FFFF, 16'hFFFF, 16'h0, 32'd0, 0));
        dir_table.push_back(mk(KIND_STATUS, 29'h0, 16'h00FF, 16'hFFFF, 32'd10, 1));
        dir_table.push_back(mk(KIND_FLAGS, 29'h1FFF_FFFF, 16'h0, 16'hFFFF, 32'd0, 0));
        dir_table.push_back(mk(KIND_FLAGS, 29'h0, 16'h0, 16'h1000, 32'd0, 0));
        dir_table.push_back(mk(KIND_REFRESH, '0, '0, '0, 32'd100, 0));
        dir_table.push_back(mk(KIND_POWER, '0, '0, '0, '0, 1));
        dir_table.push_back(mk(KIND_POWER, '0, '0, '0, '0, 0));
        dir_table.push_back(mk(KIND_STATUS, 29'h5, 16'h1234, '0, 32'd200, 0));
        dir_table.push_back(mk(KIND_FLAGS, 29'h7, '0, 16'h2008, 32'd0, 0));
        dir_table.push_back(mk(KIND_REFRESH, '0, '0, '0, 32'd700, 0));
        dir_table.push_back(mk(KIND_REFRESH, '0, '0, '0, 32'hFFFF_FFFF, 0));
        dir_table.push_back(mk(KIND_REFRESH, '0, '0, '0, 32'd0, 0));
        // Everything was just freed and rechecked, so a full power off completes.
        dir_table.push_back(typed_row(mk(KIND_POWER, '0, '0, '0, '0, 0),
                                      '{8'd0, 12'd0, 0, 1, 0, 0, 3'd0}));
        dir_table.push_back(mk(KIND_FLAGS, 29'h3, '0, 16'h3FFF, 32'd0, 0));
        dir_table.push_back(mk(KIND_REFRESH, '0, '0, '0, 32'd10, 0));
        dir_table.push_back(mk(KIND_FLAGS, 29'h3, '0, 16'hC078, 32'd0, 0));
        dir_table.push_back(mk(KIND_REFRESH, '0, '0, '0, 32'd20, 0));
        dir_table.push_back(mk(KIND_STATUS, 29'h1, 16'h0080, '0, 32'd30, 0));
        dir_table.push_back(mk(KIND_FLAGS, 29'h1, '0, 16'h2000, 32'd30, 0));
        dir_table.push_back(mk(KIND_STATUS, 29'h2, 16'h0081, '0, 32'd30, 0));
        dir_table.push_back(mk(KIND_FLAGS, 29'h2, '0, 16'h2000, 32'd30, 0));
        dir_table.push_back(mk(KIND_REFRESH, '0, '0, '0, 32'd40, 0));
        dir_table.push_back(mk(KIND_POWER, '0, '0, '0, '0, 1));

        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (dir_table[n])
            send_item(dir_table[n]);
        in_valid <= 0;
        drain();

        clock_ms = 32'd0;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            case (phase)
                0: write_reg(REG_ID_MASK, 29'h1FFF_FFFF);
                1: write_reg(REG_ID_MASK, 29'h0);
                2: write_reg(REG_ID_MASK, 29'h0000_0007);
                default: write_reg(REG_ID_MASK, $urandom_range(1) ? 29'h1FFF_FFFF
                                                                   : 29'($urandom));
            endcase
            case (phase % 3)
                0: write_reg(REG_TIMEOUT, 29'd0);
                1: write_reg(REG_TIMEOUT, 29'hFFFF);
                default: write_reg(REG_TIMEOUT, 29'($urandom_range(50, 1500)));
            endcase
            write_reg(REG_IDLE, phase < 4 ? 29'(phase) : 29'($urandom_range(3)));
            write_reg(REG_DISCHARGE, phase < 4 ? 29'(3 - phase) : 29'($urandom_range(3)));
            for (int n = 0; n < 4; n++)
                id_pool[n] = 29'($urandom);
            id_pool[0] = '0;
            id_pool[1] = 29'h1FFF_FFFF;
            @(posedge clk);

            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(19) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(0, 400);
                sel = $urandom_range(9);
                r = mk(sel < 3 ? KIND_STATUS : sel < 6 ? KIND_FLAGS
                       : sel < 8 ? KIND_REFRESH : KIND_POWER,
                       $urandom_range(4) == 0 ? 29'($urandom) : id_pool[$urandom_range(3)],
                       16'($urandom), 16'($urandom), clock_ms, 1'($urandom_range(1)));
                // Steer the pack state toward the configured codes now and then.
                if (r.k == KIND_FLAGS && $urandom_range(1))
                    r.w3[13:12] = $urandom_range(1) ? {discharge_reg[0], discharge_reg[1]}
                                                    : {idle_reg[0], idle_reg[1]};
                send_item(r);
            end
            in_valid <= 0;
            drain();
        end

        mismatches += pending_status.size();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
